// File: design/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

	// Widths of the request and result fields
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned TGT_W    = 3;
	localparam int unsigned MADDR_W  = 21;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Bank geometry
	localparam int unsigned ROM_BANK_BYTES = 16384;
	localparam int unsigned RAM_BANK_BYTES = 8192;
	localparam int unsigned ROM_OFS_W = $clog2(ROM_BANK_BYTES);
	localparam int unsigned RAM_OFS_W = $clog2(RAM_BANK_BYTES);
	localparam int unsigned ROM_BANK_W = 7;
	localparam int unsigned RAM_BANK_W = 2;

	// Result targets
	localparam logic [TGT_W-1:0] TGT_NONE  = 3'd0;
	localparam logic [TGT_W-1:0] TGT_BOOT  = 3'd1;
	localparam logic [TGT_W-1:0] TGT_ROM   = 3'd2;
	localparam logic [TGT_W-1:0] TGT_RAM   = 3'd3;
	localparam logic [TGT_W-1:0] TGT_FAULT = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_ROM_MAPPED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROM_BANKS_LOG2  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROM_FILE_BANKS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAM_SIZE_BYTES  = 2'd3;

	// Bus constants
	localparam logic [DATA_W-1:0] RAM_ENABLE_KEY = 8'h0a;
	localparam logic [2:0]        SMALL_ROM_LOG2 = 3'd5;

	typedef struct packed {
		logic        boot_rom_mapped;
		logic [2:0]  rom_banks_log2;
		logic [7:0]  rom_file_banks;
		logic [15:0] ram_size_bytes;
	} cfg_t;

	typedef struct packed {
		logic [ROM_BANK_W-1:0] rom_bank;
		logic [RAM_BANK_W-1:0] ext_bank;
		logic                  ext_ram_on;
		logic                  banking_mode;
	} bank_state_t;

	typedef struct packed {
		logic [TGT_W-1:0]   target;
		logic [MADDR_W-1:0] mapped_address;
		logic               ram_write_enable;
		logic [DATA_W-1:0]  ram_write_byte;
	} map_result_t;

endpackage

// File: design/cartridge_bank_mapper.sv
// Output: the result of an accepted request is captured in the output register.
// Throughput: one request per cycle while the output is taken; a new request is taken while the
// result is being taken, and the bank registers update at the accepting edge.
// Reset: configuration returns to boot ROM mapped, two banks, no RAM; ROM bank 1,
// RAM bank 0, RAM disabled, ROM banking mode; the output register is emptied.
module cartridge_bank_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [cbm_pkg::ADDR_W-1:0]        bus_address,
	input  logic [cbm_pkg::DATA_W-1:0]        write_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cbm_pkg::TGT_W-1:0]         target,
	output logic [cbm_pkg::MADDR_W-1:0]       mapped_address,
	output logic                              ram_write_enable,
	output logic [cbm_pkg::DATA_W-1:0]        ram_write_byte
);
	import cbm_pkg::*;

	cfg_t        cfg_q;
	bank_state_t state_q;
	bank_state_t state_next;
	map_result_t result;
	map_result_t result_q;
	logic        out_valid_q;
	logic        accept;

	// Take a request whenever the output register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	cbm_map u_map (
		.func        (func),
		.bus_address (bus_address),
		.write_data  (write_data),
		.cfg         (cfg_q),
		.state       (state_q),
		.state_next  (state_next),
		.result      (result)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_rom_mapped <= 1'b1;
			cfg_q.rom_banks_log2  <= 3'd1;
			cfg_q.rom_file_banks  <= 8'd2;
			cfg_q.ram_size_bytes  <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOOT_ROM_MAPPED: cfg_q.boot_rom_mapped <= cfg_data[0];
				REG_ROM_BANKS_LOG2:  cfg_q.rom_banks_log2  <= cfg_data[2:0];
				REG_ROM_FILE_BANKS:  cfg_q.rom_file_banks  <= cfg_data[7:0];
				REG_RAM_SIZE_BYTES:  cfg_q.ram_size_bytes  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bank registers advance on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bank     <= 7'd1;
			state_q.ext_bank     <= 2'd0;
			state_q.ext_ram_on   <= 1'b0;
			state_q.banking_mode <= 1'b0;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	// Output valid: set on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload until the next accept
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign target           = result_q.target;
	assign mapped_address   = result_q.mapped_address;
	assign ram_write_enable = result_q.ram_write_enable;
	assign ram_write_byte   = result_q.ram_write_byte;

endmodule

// File: design/cbm_map.sv
// Address decode, bank register update and mapping for one bus request.
module cbm_map (
	input  logic                           func,
	input  logic [cbm_pkg::ADDR_W-1:0]     bus_address,
	input  logic [cbm_pkg::DATA_W-1:0]     write_data,
	input  cbm_pkg::cfg_t                  cfg,
	input  cbm_pkg::bank_state_t           state,
	output cbm_pkg::bank_state_t           state_next,
	output cbm_pkg::map_result_t           result
);
	import cbm_pkg::*;

	logic [ROM_BANK_W-1:0] bank_mask;
	logic [ROM_BANK_W-1:0] lo_sel_bank;
	logic [ROM_BANK_W-1:0] hi_sel_bank;
	logic [ROM_BANK_W-1:0] upper_bank;
	logic [RAM_BANK_W-1:0] ext_bank_mask;
	logic [14:0]           ram_idx;
	logic [ROM_BANK_W-1:0] lo_fixed;
	logic [ROM_BANK_W-1:0] hi_fixed;

	// Mask of valid ROM bank bits from the bank count
	assign bank_mask = ROM_BANK_W'((8'd1 << cfg.rom_banks_log2) - 8'd1);

	// Candidate bank after a write to the low or high bank register
	assign lo_sel_bank = state.banking_mode ?
		{2'b00, write_data[4:0]} : {state.rom_bank[6:5], write_data[4:0]};
	assign hi_sel_bank = {write_data[1:0], state.rom_bank[4:0]};

	// Bump the unreachable banks, then mask to the bank count
	always_comb begin
		lo_fixed = lo_sel_bank;
		if (lo_sel_bank[4:0] == 5'd0)
			lo_fixed = lo_sel_bank + 7'd1;
		lo_fixed = lo_fixed & bank_mask;
		hi_fixed = hi_sel_bank;
		if (hi_sel_bank[4:0] == 5'd0 && hi_sel_bank[6:5] != 2'd0)
			hi_fixed = hi_sel_bank + 7'd1;
		hi_fixed = hi_fixed & bank_mask;
	end

	// Effective bank for the switchable ROM area
	assign upper_bank = (state.banking_mode || cfg.rom_banks_log2 <= SMALL_ROM_LOG2) ?
		{2'b00, state.rom_bank[4:0]} : state.rom_bank;

	// RAM bank mask wraps modulo four
	assign ext_bank_mask = cfg.ram_size_bytes[14:13] - 2'd1;

	assign ram_idx = state.banking_mode ?
		{state.ext_bank, bus_address[RAM_OFS_W-1:0]} :
		{2'b00, bus_address[RAM_OFS_W-1:0]};

	// Decode the request
	always_comb begin
		state_next = state;
		result     = '0;
		if (func && !bus_address[15]) begin
			case (bus_address[14:13])
				2'd0: state_next.ext_ram_on = (write_data == RAM_ENABLE_KEY);
				2'd1: state_next.rom_bank = lo_fixed;
				2'd2: begin
					if (state.banking_mode)
						state_next.ext_bank = write_data[1:0] & ext_bank_mask;
					else
						state_next.rom_bank = hi_fixed;
				end
				default: begin
					if (write_data == 8'd0)
						state_next.banking_mode = 1'b0;
					else if (write_data == 8'd1)
						state_next.banking_mode = 1'b1;
				end
			endcase
		end else if (bus_address[15:8] == 8'd0 && cfg.boot_rom_mapped) begin
			result.target         = TGT_BOOT;
			result.mapped_address = MADDR_W'(bus_address);
		end else if (bus_address[15:14] == 2'd0) begin
			result.target         = TGT_ROM;
			result.mapped_address = MADDR_W'(bus_address);
		end else if (bus_address[15:14] == 2'd1) begin
			if (upper_bank != '0) begin
				result.mapped_address = {upper_bank, bus_address[ROM_OFS_W-1:0]};
				result.target = ({1'b0, upper_bank} >= cfg.rom_file_banks) ?
					TGT_FAULT : TGT_ROM;
			end else begin
				result.target         = TGT_ROM;
				result.mapped_address = MADDR_W'(bus_address[ROM_OFS_W-1:0]);
			end
		end else if (bus_address[15:13] == 3'b101 && state.ext_ram_on) begin
			if ({1'b0, ram_idx} < cfg.ram_size_bytes) begin
				result.target         = TGT_RAM;
				result.mapped_address = MADDR_W'(ram_idx);
				if (func) begin
					result.ram_write_enable = 1'b1;
					result.ram_write_byte   = write_data;
				end
			end
		end
	end

endmodule
